// ===== src/hcc_pkg.sv =====
// Shared types and constants for the Hilbert curve codec.
package hcc_pkg;

   localparam int MAX_ORDER = 16;
   localparam int LEVEL_W   = $clog2(MAX_ORDER);
   localparam int ORDER_W   = 5;
   localparam int COORD_W   = 16;
   localparam int INDEX_W   = 32;

   localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(MAX_ORDER);

   typedef enum logic {
      CMD_XY2D = 1'b0,
      CMD_D2XY = 1'b1
   } hcc_cmd_type;

   // One word as it travels down the row of cells.
   typedef struct packed {
      hcc_cmd_type          command;
      logic [COORD_W-1:0]   x;
      logic [COORD_W-1:0]   y;
      logic [INDEX_W-1:0]   curve_index;
   } hcc_word_type;

endpackage

// ===== src/hilbert_curve_codec_top.sv =====
// A request word passes through the 16 level cell registers to the response word.
// Throughput: one word per cycle while rsp_stall is low; each cell holds one word.
// A stalled response holds only the cells that are full; empty cells keep filling.
// Reset clears every cell's valid flag and sets grid_order to 16.
// Top level of the Hilbert curve codec: order register and the row of level cells.
module hilbert_curve_codec_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [hcc_pkg::ORDER_W-1:0]     csr_write_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_command,
   input  logic [hcc_pkg::COORD_W-1:0]     req_x_in,
   input  logic [hcc_pkg::COORD_W-1:0]     req_y_in,
   input  logic [hcc_pkg::INDEX_W-1:0]     req_curve_index_in,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [hcc_pkg::INDEX_W-1:0]     rsp_curve_index_out,
   output logic [hcc_pkg::COORD_W-1:0]     rsp_x_out,
   output logic [hcc_pkg::COORD_W-1:0]     rsp_y_out
);
   import hcc_pkg::*;

   logic [ORDER_W-1:0]   grid_order_ff;
   logic [ORDER_W-1:0]   eff_order;
   hcc_word_type         first_word;
   hcc_word_type         word  [MAX_ORDER+1];
   logic                 valid [MAX_ORDER+1];
   logic                 take  [MAX_ORDER+1];
   hcc_word_type         last_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_order_ff <= ORDER_RESET;
      end else if (csr_write_enable) begin
         grid_order_ff <= csr_write_data;
      end
   end

   assign eff_order = (grid_order_ff > ORDER_W'(MAX_ORDER)) ?
                      ORDER_W'(MAX_ORDER) : grid_order_ff;

   // The field a command computes starts at zero; cells fill it level by level.
   always_comb begin
      first_word.command = hcc_cmd_type'(req_command);
      if (hcc_cmd_type'(req_command) == CMD_XY2D) begin
         first_word.x           = req_x_in;
         first_word.y           = req_y_in;
         first_word.curve_index = '0;
      end else begin
         first_word.x           = '0;
         first_word.y           = '0;
         first_word.curve_index = req_curve_index_in;
      end
   end

   assign word[0]          = first_word;
   assign valid[0]         = req_valid;
   assign take[MAX_ORDER]  = !rsp_stall;
   assign req_stall        = !take[0];

   for (genvar i = 0; i < MAX_ORDER; i++) begin : g_cell
      hcc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .position   (LEVEL_W'(i)),
         .order      (eff_order),
         .up_valid   (valid[i]),
         .up_word    (word[i]),
         .up_take    (take[i]),
         .down_take  (take[i+1]),
         .down_valid (valid[i+1]),
         .down_word  (word[i+1])
      );
   end

   assign last_word           = word[MAX_ORDER];
   assign rsp_valid           = valid[MAX_ORDER];
   assign rsp_curve_index_out = (last_word.command == CMD_XY2D) ? last_word.curve_index : '0;
   assign rsp_x_out           = (last_word.command == CMD_D2XY) ? last_word.x : '0;
   assign rsp_y_out           = (last_word.command == CMD_D2XY) ? last_word.y : '0;

endmodule

// ===== src/hcc_cell.sv =====
// One level of the Hilbert transform: a quadrant step plus its pipeline register.
module hcc_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [hcc_pkg::LEVEL_W-1:0]   position,
   input  logic [hcc_pkg::ORDER_W-1:0]   order,
   input  logic                          up_valid,
   input  hcc_pkg::hcc_word_type         up_word,
   output logic                          up_take,
   input  logic                          down_take,
   output logic                          down_valid,
   output hcc_pkg::hcc_word_type         down_word
);
   import hcc_pkg::*;

   logic                 valid_ff;
   hcc_word_type         data_ff;
   hcc_word_type         data_in;
   logic [LEVEL_W-1:0]   level;
   logic [COORD_W-1:0]   low_mask;
   logic                 active;
   logic                 qx;
   logic                 qy;
   logic [COORD_W-1:0]   tx;
   logic [COORD_W-1:0]   ty;

   // Encoding walks from the top bit down, decoding from the bottom bit up.
   assign level    = (up_word.command == CMD_XY2D) ?
                     (LEVEL_W'(MAX_ORDER - 1) - position) : position;
   assign active   = {1'b0, level} < order;
   assign low_mask = (COORD_W'(1) << level) - COORD_W'(1);

   always_comb begin
      data_in = up_word;
      qx      = 1'b0;
      qy      = 1'b0;
      tx      = up_word.x;
      ty      = up_word.y;
      if (active) begin
         if (up_word.command == CMD_XY2D) begin
            qx = up_word.x[level];
            qy = up_word.y[level];
            data_in.curve_index[{level, 1'b1}] = qx;
            data_in.curve_index[{level, 1'b0}] = qx ^ qy;
         end else begin
            qx = up_word.curve_index[{level, 1'b1}];
            qy = up_word.curve_index[{level, 1'b0}] ^ qx;
         end
         // Only the bits below this level are still in play, so the
         // reflection is an inversion of those bits.
         if (!qy) begin
            if (qx) begin
               tx = tx ^ low_mask;
               ty = ty ^ low_mask;
            end
            {tx, ty} = {ty, tx};
         end
         if (up_word.command == CMD_D2XY) begin
            tx[level] = qx;
            ty[level] = qy;
         end
         data_in.x = tx;
         data_in.y = ty;
      end
   end

   assign up_take = !valid_ff || down_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_take) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_take) begin
         data_ff <= data_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_word  = data_ff;

endmodule

// ===== test/tb_top.sv =====
// Testbench for the Hilbert curve codec: curve predictor, scoreboard and handshake drivers.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import hcc_pkg::*;

   typedef struct packed {
      logic [INDEX_W-1:0] curve_index;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } curve_word_type;

   class hilbert_check;
      curve_word_type     in_flight[$];
      logic [ORDER_W-1:0] grid_order;
      int unsigned        mismatches;

      function new();
         grid_order = ORDER_RESET;
         mismatches = 0;
      endfunction

      task report(string line);
         $display("ERROR at %0t: %s", $realtime, line);
         mismatches++;
      endtask

      // Walks from the largest quadrant down, adding each quadrant's offset.
      function logic [31:0] curve_distance(int unsigned ord, logic [15:0] xin,
                                           logic [15:0] yin);
         logic [31:0] side, mask, s, x, y, qx, qy, t, total;
         side = 32'd1 << ord;
         mask = side - 32'd1;
         x = {16'b0, xin} & mask;
         y = {16'b0, yin} & mask;
         total = '0;
         for (s = side >> 1; s != 0; s = s >> 1) begin
            qx = ((x & s) != 0) ? 32'd1 : 32'd0;
            qy = ((y & s) != 0) ? 32'd1 : 32'd0;
            total = total + s * s * ((32'd3 * qx) ^ qy);
            if (qy == 0) begin
               if (qx == 1) begin
                  x = s - 32'd1 - x;
                  y = s - 32'd1 - y;
               end
               t = x;
               x = y;
               y = t;
            end
            x = x & mask;
            y = y & mask;
         end
         return total;
      endfunction

      // Builds the point from the smallest sub-square outward, two index bits per level.
      function void curve_point(int unsigned ord, logic [31:0] din,
                                output logic [15:0] xo, output logic [15:0] yo);
         logic [31:0] side, s, rest, x, y, qx, qy, t;
         side = 32'd1 << ord;
         rest = din;
         x = '0;
         y = '0;
         for (s = 32'd1; s < side; s = s << 1) begin
            qx = 32'd1 & (rest >> 1);
            qy = 32'd1 & (rest ^ qx);
            if (qy == 0) begin
               if (qx == 1) begin
                  x = s - 32'd1 - x;
                  y = s - 32'd1 - y;
               end
               t = x;
               x = y;
               y = t;
            end
            x = x + s * qx;
            y = y + s * qy;
            rest = rest >> 2;
         end
         xo = x[15:0];
         yo = y[15:0];
      endfunction

      function void note_request(hcc_cmd_type cmd, logic [15:0] x, logic [15:0] y,
                                 logic [31:0] d);
         curve_word_type want;
         int unsigned    ord;
         ord = (grid_order > MAX_ORDER) ? MAX_ORDER : grid_order;
         want = '0;
         if (cmd == CMD_XY2D) begin
            want.curve_index = curve_distance(ord, x, y);
         end else begin
            curve_point(ord, d, want.x, want.y);
         end
         in_flight.push_back(want);
      endfunction

      task check_response(logic [31:0] curve_index, logic [15:0] x, logic [15:0] y);
         curve_word_type want;
         if (in_flight.size() == 0) begin
            report($sformatf("response word with none expected: index=%h x=%h y=%h",
                             curve_index, x, y));
            return;
         end
         want = in_flight.pop_front();
         if (curve_index !== want.curve_index)
            report($sformatf("curve_index_out %h, expected %h", curve_index,
                             want.curve_index));
         if (x !== want.x)
            report($sformatf("x_out %h, expected %h", x, want.x));
         if (y !== want.y)
            report($sformatf("y_out %h, expected %h", y, want.y));
      endtask
   endclass

   logic                clock;
   logic                reset              = 1'b1;
   logic                csr_write_enable   = 1'b0;
   logic [ORDER_W-1:0]  csr_write_data     = '0;
   logic                req_valid          = 1'b0;
   logic                req_stall;
   logic                req_command        = CMD_XY2D;
   logic [COORD_W-1:0]  req_x_in           = '0;
   logic [COORD_W-1:0]  req_y_in           = '0;
   logic [INDEX_W-1:0]  req_curve_index_in = '0;
   logic                rsp_valid;
   logic                rsp_stall          = 1'b0;
   logic [INDEX_W-1:0]  rsp_curve_index_out;
   logic [COORD_W-1:0]  rsp_x_out;
   logic [COORD_W-1:0]  rsp_y_out;

   hilbert_check board = new();
   bit           send_burst = 1'b0;
   bit           take_burst = 1'b0;

   hilbert_curve_codec_top i_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_x_in            (req_x_in),
      .req_y_in            (req_y_in),
      .req_curve_index_in  (req_curve_index_in),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_curve_index_out (rsp_curve_index_out),
      .rsp_x_out           (rsp_x_out),
      .rsp_y_out           (rsp_y_out)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // Offers one word after a random gap and returns at the edge that accepts it.
   task automatic send_word(hcc_cmd_type cmd, logic [15:0] x, logic [15:0] y,
                            logic [31:0] d);
      int unsigned gap;
      if ($urandom_range(0, 39) == 0)
         send_burst = !send_burst;
      gap = send_burst ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_command        <= cmd;
      req_x_in           <= x;
      req_y_in           <= y;
      req_curve_index_in <= d;
      do @(posedge clock); while (req_stall);
      board.note_request(cmd, x, y, d);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.in_flight.size() != 0) @(posedge clock);
   endtask

   task automatic write_order(logic [ORDER_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.grid_order = value;
   endtask

   function automatic logic [15:0] pick_coord();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick_index();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   // Response side: a random stall before each word, with stretches of none.
   initial begin
      int unsigned hold;
      do @(posedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 39) == 0)
            take_burst = !take_burst;
         hold = take_burst ? 0 : $urandom_range(0, 17);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         board.check_response(rsp_curve_index_out, rsp_x_out, rsp_y_out);
      end
   end

   initial begin
      int unsigned  phase_orders[12];
      int unsigned  pause_at;
      hcc_cmd_type  cmd;
      phase_orders = '{1, 2, 16, 5, 31, 8, 0, 15, 20, 3, 12, 0};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Corners and other fixed points at the reset order; the unused fields carry noise.
      send_word(CMD_XY2D, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
      send_word(CMD_XY2D, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_word(CMD_XY2D, 16'hFFFF, 16'h0000, 32'h0000_0000);
      send_word(CMD_XY2D, 16'h0000, 16'hFFFF, 32'h1234_5678);
      send_word(CMD_XY2D, 16'h8000, 16'h0000, 32'h0000_0000);
      send_word(CMD_XY2D, 16'h5555, 16'hAAAA, 32'h0000_0000);
      send_word(CMD_D2XY, 16'hFFFF, 16'hFFFF, 32'h0000_0000);
      send_word(CMD_D2XY, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_word(CMD_D2XY, 16'h0000, 16'h0000, 32'h5555_5555);
      send_word(CMD_D2XY, 16'h1234, 16'h4321, 32'hAAAA_AAAA);
      send_word(CMD_D2XY, 16'h0000, 16'h0000, 32'h8000_0000);
      wait_drained();

      // A one-cell grid maps everything to zero.
      write_order(5'd0);
      send_word(CMD_XY2D, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_word(CMD_D2XY, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      wait_drained();

      // Orders above the maximum behave as the maximum.
      write_order(5'd31);
      send_word(CMD_XY2D, 16'hFFFF, 16'h1234, 32'h0000_0000);
      send_word(CMD_D2XY, 16'h0000, 16'h0000, 32'hDEAD_BEEF);
      wait_drained();
      write_order(5'd17);
      send_word(CMD_XY2D, 16'hFFFF, 16'h1234, 32'h0000_0000);
      send_word(CMD_D2XY, 16'h0000, 16'h0000, 32'hDEAD_BEEF);
      wait_drained();

      // Bits above the order must be ignored.
      write_order(5'd3);
      send_word(CMD_XY2D, 16'hFFF5, 16'h00F2, 32'h0000_0000);
      send_word(CMD_D2XY, 16'h0000, 16'h0000, 32'hFFFF_FFC9);
      wait_drained();

      foreach (phase_orders[p]) begin
         if (p == 11)
            write_order(ORDER_W'($urandom_range(0, 31)));
         else
            write_order(ORDER_W'(phase_orders[p]));
         pause_at = $urandom_range(5, 65);
         for (int i = 0; i < 71; i++) begin
            if (i == pause_at)
               wait_drained();
            cmd = hcc_cmd_type'($urandom_range(0, 1));
            send_word(cmd, pick_coord(), pick_coord(), pick_index());
         end
         wait_drained();
      end

      repeat (24) @(posedge clock);
      if (board.mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
